// ===== rtl/lqrb_pkg.sv =====
// ----------------------------------------------------------------------------
// lqrb_pkg
// Shared types and constants for the balance controller with trapezoidal ramp.
// ----------------------------------------------------------------------------
package lqrb_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned PROD_W    = 64;
    localparam int unsigned VOLT_W    = 22;
    localparam int unsigned LIMIT_W   = 21;
    localparam int unsigned SPEED_W   = 31;
    localparam int unsigned DRIFT_W   = 48;
    localparam int unsigned CFG_IDX_W = 3;

    typedef logic signed [DATA_W-1:0] q16_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_POSITION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_VELOCITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PITCH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RATE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_OFFSET  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_SPEED = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_LIMIT = 3'd6;

    // Slots of the gain and error arrays.
    localparam logic [1:0] TERM_POSITION = 2'd0;
    localparam logic [1:0] TERM_VELOCITY = 2'd1;
    localparam logic [1:0] TERM_PITCH    = 2'd2;
    localparam logic [1:0] TERM_RATE     = 2'd3;

    localparam q16_t GAIN_POSITION_RST = 32'sd3412460;
    localparam q16_t GAIN_VELOCITY_RST = 32'sd157286;
    localparam q16_t GAIN_PITCH_RST    = 32'sd98304;
    localparam q16_t GAIN_RATE_RST     = 32'sd22479;
    localparam q16_t PITCH_OFFSET_RST  = -32'sd17695;
    localparam logic [SPEED_W-1:0] DEFAULT_SPEED_RST = 31'd9830;
    localparam logic [LIMIT_W-1:0] VOLTAGE_LIMIT_RST = 21'd393216;

    localparam q16_t Q16_MAX = 32'sd2147483647;
    localparam q16_t Q16_MIN = -32'sd2147483648;

    // Profile constants in Q16.16 LSBs; DT_Q32 is the 5 ms tick in Q0.32.
    localparam logic [31:0]        SNAP_MAX  = 32'd327;
    localparam logic [32:0]        SPEED_MIN = 33'd328;
    localparam logic signed [32:0] SLEW_STEP = 33'sd131;
    localparam q16_t               VEL_CLAMP = 32'sd52429;
    localparam q16_t               DT_Q32    = 32'sd21474836;

    // Rounding offsets.
    localparam prod_t              SETPOINT_ROUND = 64'sd2147483648;
    localparam logic signed [49:0] DRIFT_ROUND    = 50'sd4000;
    localparam logic signed [48:0] OFFSET_ROUND   = 49'sd32768;
    localparam prod_t              VOLT_ROUND     = 64'sd8192;

    // Drift divide by 8000: a shift by 6, then base-256 long division by 125.
    // Each quotient digit is floor(x * 67109 / 2^23), exact for x below 32000.
    localparam int unsigned DIGIT_W    = 8;
    localparam int unsigned DIV_DIGITS = 6;
    localparam int unsigned DIV_W      = DIGIT_W * DIV_DIGITS;
    localparam int unsigned REM_W      = 7;
    localparam int unsigned DIV_SHIFT  = 23;
    localparam q16_t        DIV_RECIP  = 32'sd67109;

    localparam logic [2:0] DIV_LAST = 3'(DIV_DIGITS - 1);
    localparam logic [2:0] MAC_LAST = 3'd4;

endpackage

// ===== rtl/lqr_balance_with_trapezoid_ramp.sv =====
// ----------------------------------------------------------------------------
// lqr_balance_with_trapezoid_ramp
// Balancing state-feedback controller with a trapezoidal position profile.
// ----------------------------------------------------------------------------
// Each item is one 5 ms control tick. The block steps the position setpoint
// and ramp velocity, updates the drift integrator and returns the clamped
// drive voltage together with the new ramp velocity and setpoint. All
// products go through a single registered 32 x 32 multiplier under a small
// sequencer, so one item occupies the block from acceptance until its
// result is loaded, through the six base-256 digit steps of the drift
// divide and the four gain products. The next item is taken in the cycle
// after the result is loaded, and the load waits while an earlier result
// is still unaccepted. A new item may be accepted while the previous result
// is still waiting on out_ready. Configuration writes take effect at once and
// should only be issued while the block is idle.
module lqr_balance_with_trapezoid_ramp (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  lqrb_pkg::q16_t                         measured_position,
    input  lqrb_pkg::q16_t                         measured_velocity,
    input  lqrb_pkg::q16_t                         measured_pitch,
    input  lqrb_pkg::q16_t                         measured_rate,
    input  lqrb_pkg::q16_t                         target_position,
    input  lqrb_pkg::q16_t                         target_velocity,
    input  lqrb_pkg::q16_t                         target_pitch,
    input  lqrb_pkg::q16_t                         target_rate,

    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [lqrb_pkg::VOLT_W-1:0]     drive_voltage,
    output lqrb_pkg::q16_t                         ramped_velocity,
    output lqrb_pkg::q16_t                         position_setpoint,

    input  logic                                   cfg_we,
    input  logic [lqrb_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lqrb_pkg::DATA_W-1:0]            cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_RAMP,
        S_ADV,
        S_SP,
        S_ERR,
        S_DIV_MUL,
        S_DIV_SUB,
        S_DRIFT,
        S_ERRS,
        S_MAC,
        S_OUT
    } state_t;

    function automatic lqrb_pkg::q16_t sat_q16(input logic signed [34:0] x);
        lqrb_pkg::q16_t r;
        if (x > 35'(lqrb_pkg::Q16_MAX))
            r = lqrb_pkg::Q16_MAX;
        else if (x < 35'(lqrb_pkg::Q16_MIN))
            r = lqrb_pkg::Q16_MIN;
        else
            r = x[31:0];
        return r;
    endfunction

    // Configuration
    lqrb_pkg::q16_t                      gain_reg [4];
    lqrb_pkg::q16_t                      pitch_offset_reg;
    logic [lqrb_pkg::SPEED_W-1:0]        default_speed_reg;
    logic [lqrb_pkg::LIMIT_W-1:0]        voltage_limit_reg;

    // Sequencer and controller state
    state_t                              state_reg;
    logic [2:0]                          cnt_reg;
    lqrb_pkg::q16_t                      setpoint_reg;
    lqrb_pkg::q16_t                      ramp_velocity_reg;
    logic signed [lqrb_pkg::DRIFT_W-1:0] drift_offset_reg;

    // Output register
    logic                                out_valid_reg;
    logic signed [lqrb_pkg::VOLT_W-1:0]  volt_out_reg;
    lqrb_pkg::q16_t                      vel_out_reg;
    lqrb_pkg::q16_t                      sp_out_reg;

    // Item and work registers
    lqrb_pkg::q16_t                      mpos_reg;
    lqrb_pkg::q16_t                      mvel_reg;
    lqrb_pkg::q16_t                      mpit_reg;
    lqrb_pkg::q16_t                      mrate_reg;
    lqrb_pkg::q16_t                      tpos_reg;
    lqrb_pkg::q16_t                      tvel_reg;
    lqrb_pkg::q16_t                      tpit_reg;
    lqrb_pkg::q16_t                      trate_reg;
    logic [lqrb_pkg::DIV_W-1:0]          dividend_reg;
    logic [lqrb_pkg::DIV_W-1:0]          quot_reg;
    logic [lqrb_pkg::REM_W-1:0]          rem_reg;
    logic                                div_neg_reg;
    lqrb_pkg::q16_t                      x_reg [4];
    lqrb_pkg::prod_t                     acc_reg;

    // Shared multiplier
    lqrb_pkg::q16_t                      mul_a;
    lqrb_pkg::q16_t                      mul_b;
    lqrb_pkg::prod_t                     prod;

    // Ramp logic
    lqrb_pkg::q16_t                      ramp_next;
    logic [32:0]                         tvel_abs;
    logic [30:0]                         trav;
    logic signed [32:0]                  err_w;
    logic signed [32:0]                  err_neg;
    logic [31:0]                         aerr;
    logic                                snap;
    lqrb_pkg::q16_t                      v_neg;
    logic [31:0]                         av;
    logic                                av_big;
    logic [63:0]                         sq_u;
    logic [63:0]                         sq11;
    logic                                brake;
    lqrb_pkg::q16_t                      desired;
    logic signed [32:0]                  diff;
    logic signed [32:0]                  v_step;

    // Setpoint advance
    lqrb_pkg::prod_t                     adv_rnd;
    lqrb_pkg::q16_t                      adv_step;
    lqrb_pkg::q16_t                      setpoint_next;

    // Drift integrator
    logic signed [32:0]                  dpos;
    logic signed [49:0]                  drift_err;
    logic [43:0]                         div_m;
    logic [43:0]                         div_mag;
    logic [lqrb_pkg::REM_W+lqrb_pkg::DIGIT_W-1:0] div_x;
    logic [lqrb_pkg::DIGIT_W-1:0]        qd;
    logic [lqrb_pkg::REM_W+lqrb_pkg::DIGIT_W-1:0] qx;
    logic [lqrb_pkg::REM_W+lqrb_pkg::DIGIT_W-1:0] rem_full;
    logic [48:0]                         delta;
    logic signed [48:0]                  drift_sum;
    logic signed [lqrb_pkg::DRIFT_W-1:0] drift_next;

    // Error terms and output voltage
    logic signed [48:0]                  off_sum;
    logic signed [32:0]                  off;
    lqrb_pkg::q16_t                      mvel_c;
    lqrb_pkg::q16_t                      x_next [4];
    lqrb_pkg::prod_t                     acc_rnd;
    logic signed [49:0]                  vq;
    logic signed [50:0]                  nv;
    logic signed [50:0]                  lim;
    logic signed [50:0]                  vsat;

    lqrb_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg[lqrb_pkg::TERM_POSITION] <= lqrb_pkg::GAIN_POSITION_RST;
            gain_reg[lqrb_pkg::TERM_VELOCITY] <= lqrb_pkg::GAIN_VELOCITY_RST;
            gain_reg[lqrb_pkg::TERM_PITCH]    <= lqrb_pkg::GAIN_PITCH_RST;
            gain_reg[lqrb_pkg::TERM_RATE]     <= lqrb_pkg::GAIN_RATE_RST;
            pitch_offset_reg                  <= lqrb_pkg::PITCH_OFFSET_RST;
            default_speed_reg                 <= lqrb_pkg::DEFAULT_SPEED_RST;
            voltage_limit_reg                 <= lqrb_pkg::VOLTAGE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lqrb_pkg::CFG_GAIN_POSITION: gain_reg[lqrb_pkg::TERM_POSITION] <= cfg_data;
                lqrb_pkg::CFG_GAIN_VELOCITY: gain_reg[lqrb_pkg::TERM_VELOCITY] <= cfg_data;
                lqrb_pkg::CFG_GAIN_PITCH:    gain_reg[lqrb_pkg::TERM_PITCH]    <= cfg_data;
                lqrb_pkg::CFG_GAIN_RATE:     gain_reg[lqrb_pkg::TERM_RATE]     <= cfg_data;
                lqrb_pkg::CFG_PITCH_OFFSET:  pitch_offset_reg  <= cfg_data;
                lqrb_pkg::CFG_DEFAULT_SPEED:
                    default_speed_reg <= cfg_data[lqrb_pkg::SPEED_W-1:0];
                lqrb_pkg::CFG_VOLTAGE_LIMIT:
                    voltage_limit_reg <= cfg_data[lqrb_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Multiplier operand selection
    // ------------------------------------------------------------------
    always_comb
    begin
        unique case (state_reg)
            S_SQ:
            begin
                mul_a = av;
                mul_b = av;
            end
            S_ADV:
            begin
                mul_a = ramp_velocity_reg;
                mul_b = lqrb_pkg::DT_Q32;
            end
            S_DIV_MUL:
            begin
                mul_a = lqrb_pkg::q16_t'(div_x);
                mul_b = lqrb_pkg::DIV_RECIP;
            end
            S_MAC:
            begin
                mul_a = gain_reg[cnt_reg[1:0]];
                mul_b = x_reg[cnt_reg[1:0]];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Ramp velocity and setpoint
    // ------------------------------------------------------------------
    always_comb
    begin
        tvel_abs = tvel_reg[31] ? 33'(-33'(tvel_reg)) : 33'(tvel_reg);
        if (tvel_abs >= lqrb_pkg::SPEED_MIN)
            trav = (tvel_abs[32:31] != 2'b00) ? '1 : tvel_abs[30:0];
        else
            trav = default_speed_reg;

        err_w   = 33'(tpos_reg) - 33'(setpoint_reg);
        err_neg = -err_w;
        aerr    = err_w[32] ? err_neg[31:0] : err_w[31:0];
        snap    = (aerr <= lqrb_pkg::SNAP_MAX);

        v_neg  = -ramp_velocity_reg;
        av     = ramp_velocity_reg[31] ? v_neg : ramp_velocity_reg;
        av_big = av[31] | av[30];

        // Brake inside 1.1x the stopping distance: |err| * 2^19 <= 11 * v^2.
        sq_u  = prod;
        sq11  = {sq_u[60:0], 3'b000} + {sq_u[62:0], 1'b0} + sq_u;
        brake = av_big || (64'({aerr, 19'b0}) <= sq11);

        if (snap || brake)
            desired = '0;
        else if (!err_w[32])
            desired = lqrb_pkg::q16_t'({1'b0, trav});
        else
            desired = -lqrb_pkg::q16_t'({1'b0, trav});

        diff = 33'(desired) - 33'(ramp_velocity_reg);
        if (diff <= lqrb_pkg::SLEW_STEP && diff >= -lqrb_pkg::SLEW_STEP)
            v_step = 33'(desired);
        else if (!diff[32])
            v_step = 33'(ramp_velocity_reg) + lqrb_pkg::SLEW_STEP;
        else
            v_step = 33'(ramp_velocity_reg) - lqrb_pkg::SLEW_STEP;
        ramp_next = v_step[31:0];

        adv_rnd       = prod + lqrb_pkg::SETPOINT_ROUND;
        adv_step      = adv_rnd[63:32];
        setpoint_next = sat_q16(35'(setpoint_reg) + 35'(adv_step));
    end

    // ------------------------------------------------------------------
    // Drift integrator: floor((e + 4000) / 8000) as floor((.. >> 6) / 125)
    // ------------------------------------------------------------------
    always_comb
    begin
        dpos      = 33'(mpos_reg) - 33'(setpoint_reg);
        drift_err = $signed({dpos[32], dpos, 16'b0}) - 50'(drift_offset_reg)
                  + lqrb_pkg::DRIFT_ROUND;
        div_m     = drift_err[49:6];
        // A negative dividend is divided as its one's complement, whose
        // quotient is complemented back afterwards.
        div_mag   = div_m[43] ? ~div_m : div_m;

        div_x    = {rem_reg, dividend_reg[lqrb_pkg::DIV_W-1 -: lqrb_pkg::DIGIT_W]};
        qd       = prod[lqrb_pkg::DIV_SHIFT +: lqrb_pkg::DIGIT_W];
        // 125 * q = 128 * q - 4 * q + q
        qx       = {qd, 7'b0} - {5'b0, qd, 2'b0} + {7'b0, qd};
        rem_full = div_x - qx;

        delta      = div_neg_reg ? ~{1'b0, quot_reg} : {1'b0, quot_reg};
        drift_sum  = 49'(drift_offset_reg) + $signed(delta);
        if (drift_sum[48] != drift_sum[47])
            drift_next = drift_sum[48] ? {1'b1, {(lqrb_pkg::DRIFT_W-1){1'b0}}}
                                       : {1'b0, {(lqrb_pkg::DRIFT_W-1){1'b1}}};
        else
            drift_next = drift_sum[47:0];
    end

    // ------------------------------------------------------------------
    // Error terms and voltage
    // ------------------------------------------------------------------
    always_comb
    begin
        off_sum = 49'(drift_offset_reg) + lqrb_pkg::OFFSET_ROUND;
        off     = off_sum[48:16];

        if (mvel_reg > lqrb_pkg::VEL_CLAMP)
            mvel_c = lqrb_pkg::VEL_CLAMP;
        else if (mvel_reg < -lqrb_pkg::VEL_CLAMP)
            mvel_c = -lqrb_pkg::VEL_CLAMP;
        else
            mvel_c = mvel_reg;

        x_next[lqrb_pkg::TERM_POSITION] =
            sat_q16(35'(mpos_reg) - 35'(setpoint_reg) - 35'(off));
        x_next[lqrb_pkg::TERM_VELOCITY] =
            sat_q16(35'(mvel_c) - 35'(ramp_velocity_reg));
        x_next[lqrb_pkg::TERM_PITCH] =
            sat_q16(35'(mpit_reg) - 35'(pitch_offset_reg) - 35'(tpit_reg));
        x_next[lqrb_pkg::TERM_RATE] =
            sat_q16(35'(mrate_reg) - 35'(trate_reg));

        acc_rnd = acc_reg + lqrb_pkg::VOLT_ROUND;
        vq      = acc_rnd[63:14];
        nv      = -51'(vq);
        lim     = $signed({30'b0, voltage_limit_reg});
        if (nv > lim)
            vsat = lim;
        else if (nv < -lim)
            vsat = -lim;
        else
            vsat = nv;
    end

    // ------------------------------------------------------------------
    // Sequencer, controller state and output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            cnt_reg           <= '0;
            setpoint_reg      <= '0;
            ramp_velocity_reg <= '0;
            drift_offset_reg  <= '0;
            out_valid_reg     <= 1'b0;
            volt_out_reg      <= '0;
            vel_out_reg       <= '0;
            sp_out_reg        <= '0;
        end
        else
        begin
            // In S_OUT the result load below owns the valid flag.
            if (out_valid_reg && out_ready && state_reg != S_OUT)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    state_reg <= S_RAMP;
                end
                S_RAMP:
                begin
                    ramp_velocity_reg <= ramp_next;
                    if (snap)
                        setpoint_reg <= tpos_reg;
                    state_reg <= S_ADV;
                end
                S_ADV:
                begin
                    state_reg <= S_SP;
                end
                S_SP:
                begin
                    setpoint_reg <= setpoint_next;
                    state_reg    <= S_ERR;
                end
                S_ERR:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV_MUL;
                end
                S_DIV_MUL:
                begin
                    state_reg <= S_DIV_SUB;
                end
                S_DIV_SUB:
                begin
                    if (cnt_reg == lqrb_pkg::DIV_LAST)
                        state_reg <= S_DRIFT;
                    else
                    begin
                        cnt_reg   <= cnt_reg + 3'd1;
                        state_reg <= S_DIV_MUL;
                    end
                end
                S_DRIFT:
                begin
                    drift_offset_reg <= drift_next;
                    state_reg        <= S_ERRS;
                end
                S_ERRS:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    if (cnt_reg == lqrb_pkg::MAC_LAST)
                        state_reg <= S_OUT;
                    else
                        cnt_reg <= cnt_reg + 3'd1;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        volt_out_reg  <= vsat[lqrb_pkg::VOLT_W-1:0];
                        vel_out_reg   <= ramp_velocity_reg;
                        sp_out_reg    <= setpoint_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Item capture and work registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mpos_reg  <= measured_position;
            mvel_reg  <= measured_velocity;
            mpit_reg  <= measured_pitch;
            mrate_reg <= measured_rate;
            tpos_reg  <= target_position;
            tvel_reg  <= target_velocity;
            tpit_reg  <= target_pitch;
            trate_reg <= target_rate;
        end

        unique case (state_reg)
            S_ERR:
            begin
                dividend_reg <= lqrb_pkg::DIV_W'(div_mag);
                div_neg_reg  <= div_m[43];
                rem_reg      <= '0;
                quot_reg     <= '0;
            end
            S_DIV_SUB:
            begin
                rem_reg      <= rem_full[lqrb_pkg::REM_W-1:0];
                dividend_reg <= {dividend_reg[lqrb_pkg::DIV_W-lqrb_pkg::DIGIT_W-1:0],
                                 {lqrb_pkg::DIGIT_W{1'b0}}};
                quot_reg     <= {quot_reg[lqrb_pkg::DIV_W-lqrb_pkg::DIGIT_W-1:0], qd};
            end
            S_ERRS:
            begin
                x_reg   <= x_next;
                acc_reg <= '0;
            end
            S_MAC:
            begin
                // The multiplier product is registered, so each step adds the product of the previous slot.
                if (cnt_reg != 3'd0)
                    acc_reg <= acc_reg + (prod >>> 2);
            end
            default: ;
        endcase
    end

    assign in_ready          = (state_reg == S_IDLE);
    assign out_valid         = out_valid_reg;
    assign drive_voltage     = volt_out_reg;
    assign ramped_velocity   = vel_out_reg;
    assign position_setpoint = sp_out_reg;

endmodule

// ===== rtl/lqrb_mul.sv =====
// ----------------------------------------------------------------------------
// lqrb_mul
// Shared signed 32 x 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module lqrb_mul (
    input  logic                 clk,
    input  lqrb_pkg::q16_t       a,
    input  lqrb_pkg::q16_t       b,
    output lqrb_pkg::prod_t      p
);

    lqrb_pkg::prod_t p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= lqrb_pkg::prod_t'(a) * lqrb_pkg::prod_t'(b);
    end

    assign p = p_reg;

endmodule

// ===== rtl/lqrb_checker.sv =====
// ----------------------------------------------------------------------------
// lqrb_checker
// Port-level checks for the balance controller, bound to the top level.
// ----------------------------------------------------------------------------
module lqrb_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [lqrb_pkg::VOLT_W-1:0] drive_voltage,
    input lqrb_pkg::q16_t                     ramped_velocity,
    input lqrb_pkg::q16_t                     position_setpoint
);

    // The block works on one item at a time.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready stayed high after an item was accepted");

    // A result only appears at the end of a computation, never from idle.
    a_result_from_work: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while the block was idle");

    // A stalled result holds.
    a_result_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive_voltage)
            && $stable(ramped_velocity) && $stable(position_setpoint))
        else $error("stalled result changed or dropped");

    // The symmetric clamp can never produce the most negative code.
    a_volt_symmetric: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> drive_voltage != {1'b1, {(lqrb_pkg::VOLT_W-1){1'b0}}})
        else $error("drive voltage outside the symmetric limit");

endmodule

bind lqr_balance_with_trapezoid_ramp lqrb_checker u_lqrb_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .drive_voltage     (drive_voltage),
    .ramped_velocity   (ramped_velocity),
    .position_setpoint (position_setpoint)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the balance controller with trapezoidal ramp.
// Control ticks go in over a valid/ready channel. A bit-exact software copy
// of the profile generator, drift integrator and gain stage predicts each
// result, and every result is checked field by field in arrival order.
// Both sides idle and stall at random, and register settings are swept
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct packed {
        lqrb_pkg::q16_t measured_position;
        lqrb_pkg::q16_t measured_velocity;
        lqrb_pkg::q16_t measured_pitch;
        lqrb_pkg::q16_t measured_rate;
        lqrb_pkg::q16_t target_position;
        lqrb_pkg::q16_t target_velocity;
        lqrb_pkg::q16_t target_pitch;
        lqrb_pkg::q16_t target_rate;
    } tick_t;

    typedef struct packed {
        logic signed [lqrb_pkg::VOLT_W-1:0] drive_voltage;
        lqrb_pkg::q16_t                     ramped_velocity;
        lqrb_pkg::q16_t                     position_setpoint;
    } result_t;

    localparam longint SNAP_BAND    = 327;
    localparam longint CRUISE_FLOOR = 328;
    localparam longint SLEW_LSB     = 131;
    localparam longint VEL_BOUND    = 52429;
    localparam longint TICK_DT      = 21474836;
    localparam longint HALF_Q32     = 64'sd2147483648;
    localparam longint S32_MAX      = 64'sd2147483647;
    localparam longint S32_MIN      = -64'sd2147483648;
    localparam longint S48_MAX      = 64'sd140737488355327;
    localparam longint S48_MIN      = -64'sd140737488355328;
    localparam int     BLOCK_CYCLES = 30;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_ready;
    lqrb_pkg::q16_t                     measured_position;
    lqrb_pkg::q16_t                     measured_velocity;
    lqrb_pkg::q16_t                     measured_pitch;
    lqrb_pkg::q16_t                     measured_rate;
    lqrb_pkg::q16_t                     target_position;
    lqrb_pkg::q16_t                     target_velocity;
    lqrb_pkg::q16_t                     target_pitch;
    lqrb_pkg::q16_t                     target_rate;
    logic                               out_valid;
    logic                               out_ready;
    logic signed [lqrb_pkg::VOLT_W-1:0] drive_voltage;
    lqrb_pkg::q16_t                     ramped_velocity;
    lqrb_pkg::q16_t                     position_setpoint;
    logic                               cfg_we;
    logic [lqrb_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [lqrb_pkg::DATA_W-1:0]        cfg_data;

    // Predicted controller state and register copies.
    longint profile_setpoint;
    longint profile_velocity;
    longint drift_acc;
    longint gain_q [lqrb_pkg::TERM_POSITION:lqrb_pkg::TERM_RATE];
    longint pitch_trim;
    longint cruise_default;
    longint volt_limit;

    logic [lqrb_pkg::DATA_W-1:0] cfg_image [lqrb_pkg::CFG_GAIN_POSITION:
                                            lqrb_pkg::CFG_VOLTAGE_LIMIT];
    result_t           expected_ticks [$];
    result_t           due;
    int                errors = 0;
    int                ready_hold = 0;
    bit                steady = 1'b0;

    lqr_balance_with_trapezoid_ramp dut (.*);

    always #5 clk = ~clk;

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic longint mag(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic longint floor_div(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d != 0) && (n < 0))
            q = q - 1;
        return q;
    endfunction

    function automatic int spread(input int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 30);
        else
            return $urandom_range(31, 90);
    endfunction

    task automatic reset_predictor();
        profile_setpoint                = 0;
        profile_velocity                = 0;
        drift_acc                       = 0;
        gain_q[lqrb_pkg::TERM_POSITION] = lqrb_pkg::GAIN_POSITION_RST;
        gain_q[lqrb_pkg::TERM_VELOCITY] = lqrb_pkg::GAIN_VELOCITY_RST;
        gain_q[lqrb_pkg::TERM_PITCH]    = lqrb_pkg::GAIN_PITCH_RST;
        gain_q[lqrb_pkg::TERM_RATE]     = lqrb_pkg::GAIN_RATE_RST;
        pitch_trim                      = lqrb_pkg::PITCH_OFFSET_RST;
        cruise_default                  = lqrb_pkg::DEFAULT_SPEED_RST;
        volt_limit                      = lqrb_pkg::VOLTAGE_LIMIT_RST;
    endtask

    task automatic apply_register(input logic [lqrb_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [lqrb_pkg::DATA_W-1:0] d);
        case (idx)
            lqrb_pkg::CFG_GAIN_POSITION:
                gain_q[lqrb_pkg::TERM_POSITION] = longint'($signed(d));
            lqrb_pkg::CFG_GAIN_VELOCITY:
                gain_q[lqrb_pkg::TERM_VELOCITY] = longint'($signed(d));
            lqrb_pkg::CFG_GAIN_PITCH:
                gain_q[lqrb_pkg::TERM_PITCH]    = longint'($signed(d));
            lqrb_pkg::CFG_GAIN_RATE:
                gain_q[lqrb_pkg::TERM_RATE]     = longint'($signed(d));
            lqrb_pkg::CFG_PITCH_OFFSET:
                pitch_trim     = longint'($signed(d));
            lqrb_pkg::CFG_DEFAULT_SPEED:
                cruise_default = longint'(d[lqrb_pkg::SPEED_W-1:0]);
            lqrb_pkg::CFG_VOLTAGE_LIMIT:
                volt_limit     = longint'(d[lqrb_pkg::LIMIT_W-1:0]);
            default: ;
        endcase
    endtask

    // One control tick: setpoint profile, drift integrator, then gain stage.
    function automatic result_t control_tick(input tick_t t);
        longint    mp, mv, mpt, mr, tp, tv, tpt, tr;
        longint    cruise, err, aerr, want, v, diff, e, x1, x2, x3, x4, acc, volt;
        logic [63:0] av, lhs, rhs;
        bit        brake;
        result_t   r;
        mp  = t.measured_position;
        mv  = t.measured_velocity;
        mpt = t.measured_pitch;
        mr  = t.measured_rate;
        tp  = t.target_position;
        tv  = t.target_velocity;
        tpt = t.target_pitch;
        tr  = t.target_rate;

        cruise = (mag(tv) >= CRUISE_FLOOR) ? clip(mag(tv), 0, S32_MAX) : cruise_default;
        v    = profile_velocity;
        err  = tp - profile_setpoint;
        aerr = mag(err);
        if (aerr <= SNAP_BAND) begin
            want = 0;
            profile_setpoint = tp;
        end else begin
            av = mag(v);
            // Brake when inside 1.1 times the stopping distance.
            if (av >= (64'd1 << 30)) begin
                brake = 1'b1;
            end else begin
                lhs   = aerr;
                lhs   = lhs << 19;
                rhs   = 64'd11 * av * av;
                brake = (lhs <= rhs);
            end
            want = brake ? 0 : ((err > 0) ? cruise : -cruise);
        end

        diff = want - v;
        if (mag(diff) <= SLEW_LSB)
            v = want;
        else
            v = v + ((diff > 0) ? SLEW_LSB : -SLEW_LSB);
        profile_velocity = v;

        profile_setpoint = clip(profile_setpoint + ((v * TICK_DT + HALF_Q32) >>> 32),
                                S32_MIN, S32_MAX);

        e = (mp - profile_setpoint) * 65536 - drift_acc;
        drift_acc = clip(drift_acc + floor_div(e + 4000, 8000), S48_MIN, S48_MAX);

        x1 = clip(mp - profile_setpoint - ((drift_acc + 32768) >>> 16), S32_MIN, S32_MAX);
        x2 = clip(clip(mv, -VEL_BOUND, VEL_BOUND) - v, S32_MIN, S32_MAX);
        x3 = clip(mpt - pitch_trim - tpt, S32_MIN, S32_MAX);
        x4 = clip(mr - tr, S32_MIN, S32_MAX);

        acc = ((gain_q[lqrb_pkg::TERM_POSITION] * x1) >>> 2)
            + ((gain_q[lqrb_pkg::TERM_VELOCITY] * x2) >>> 2)
            + ((gain_q[lqrb_pkg::TERM_PITCH] * x3) >>> 2)
            + ((gain_q[lqrb_pkg::TERM_RATE] * x4) >>> 2);
        volt = -((acc + 8192) >>> 14);
        volt = clip(volt, -volt_limit, volt_limit);

        r.drive_voltage     = volt[lqrb_pkg::VOLT_W-1:0];
        r.ramped_velocity   = v[31:0];
        r.position_setpoint = profile_setpoint[31:0];
        return r;
    endfunction

    // Leaves in_valid high on return so that a back-to-back item follows
    // with no low gap; a later call that picks a gap, or drain_results, lowers it.
    task automatic send_tick(input tick_t t);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        {measured_position, measured_velocity, measured_pitch, measured_rate,
         target_position, target_velocity, target_pitch, target_rate} <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_ticks.push_back(control_tick(t));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_ticks.size() != 0)
            @(posedge clk);
        repeat (BLOCK_CYCLES) @(posedge clk);
    endtask

    // Writes every register from cfg_image; the block must be idle.
    task automatic write_config();
        for (int i = lqrb_pkg::CFG_GAIN_POSITION; i <= lqrb_pkg::CFG_VOLTAGE_LIMIT; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= lqrb_pkg::CFG_IDX_W'(i);
            cfg_data  <= cfg_image[i];
            apply_register(lqrb_pkg::CFG_IDX_W'(i), cfg_image[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic flag_mismatch(input string field, input longint want, input longint got);
        errors++;
        $error("%s: expected %0d, got %0d", field, want, got);
    endtask

    // Moves toward targets held for a stretch of ticks, with measurements
    // near the setpoint, plus a share of fully random items.
    task automatic run_profile(input int count);
        int     left;
        int     roll;
        int     speed;
        longint goal;
        longint offset;
        tick_t  t;
        left  = 0;
        speed = 0;
        goal  = 0;
        repeat (count) begin
            if (left == 0) begin
                left   = $urandom_range(20, 400);
                roll   = $urandom_range(0, 99);
                offset = (roll < 15) ? $urandom_range(0, 400) : $urandom_range(401, 12000);
                if ($urandom_range(0, 1))
                    offset = -offset;
                goal  = clip(profile_setpoint + offset, S32_MIN, S32_MAX);
                roll  = $urandom_range(0, 99);
                speed = (roll < 25) ? $urandom_range(0, 327) : $urandom_range(328, 30000);
                if ($urandom_range(0, 1))
                    speed = -speed;
            end
            left--;
            if ($urandom_range(0, 99) == 0)
                steady = !steady;
            if ($urandom_range(0, 99) < 8) begin
                t = {$urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom(), $urandom()};
            end else begin
                t.measured_position = 32'(clip(profile_setpoint + spread(3000),
                                               S32_MIN, S32_MAX));
                t.measured_velocity = spread(70000);
                t.measured_pitch    = spread(20000);
                t.measured_rate     = spread(100000);
                t.target_position   = 32'(goal);
                t.target_velocity   = speed;
                t.target_pitch      = spread(5000);
                t.target_rate       = spread(5000);
            end
            send_tick(t);
        end
        steady = 1'b0;
    endtask

    task automatic test_directed();
        tick_t t;
        t = '0;
        send_tick(t);
        // Setpoint snaps just inside the band on either side.
        t.target_position = 327;
        send_tick(t);
        t.target_position = 0;
        send_tick(t);
        // Just outside the band, speed 327 takes the default, 328 is used as given.
        t.target_position = 328;
        t.target_velocity = 327;
        send_tick(t);
        t.target_position = -400;
        t.target_velocity = 328;
        send_tick(t);
        // Most negative target speed saturates the cruise speed.
        t.target_position = 5000;
        t.target_velocity = lqrb_pkg::Q16_MIN;
        send_tick(t);
        t = '0;
        t.measured_velocity = lqrb_pkg::VEL_CLAMP + 1;
        send_tick(t);
        t.measured_velocity = -lqrb_pkg::VEL_CLAMP - 1;
        send_tick(t);
        t.measured_velocity = lqrb_pkg::VEL_CLAMP;
        send_tick(t);
        t = {8{32'h7FFF_FFFF}};
        send_tick(t);
        t = {8{32'h8000_0000}};
        send_tick(t);
        t = {8{32'hFFFF_FFFF}};
        send_tick(t);
        t = {4{32'h5555_5555, 32'hAAAA_AAAA}};
        send_tick(t);
        t = '0;
        send_tick(t);
        drain_results();
    endtask

    // The receiver holds off while items keep coming back to back, so the
    // block fills and stalls its input; then the sender waits for the drain.
    task automatic test_backpressure();
        tick_t t;
        steady     = 1'b1;
        ready_hold = 250;
        repeat (12) begin
            t = {$urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom(), $urandom()};
            send_tick(t);
        end
        steady = 1'b0;
        drain_results();
    endtask

    task automatic test_register_extremes();
        for (int s = 0; s < 4; s++) begin
            drain_results();
            for (int i = lqrb_pkg::CFG_GAIN_POSITION; i <= lqrb_pkg::CFG_VOLTAGE_LIMIT;
                 i++) begin
                case (s)
                    0: cfg_image[i] = (i >= lqrb_pkg::CFG_DEFAULT_SPEED) ? 32'hFFFF_FFFF
                                                                          : 32'h7FFF_FFFF;
                    1: cfg_image[i] = (i >= lqrb_pkg::CFG_DEFAULT_SPEED) ? 32'h0000_0000
                                                                          : 32'h8000_0000;
                    2: cfg_image[i] = $urandom();
                    default: cfg_image[i] = '0;
                endcase
            end
            if (s == 3) begin
                cfg_image[lqrb_pkg::CFG_GAIN_POSITION] = lqrb_pkg::GAIN_POSITION_RST;
                cfg_image[lqrb_pkg::CFG_GAIN_VELOCITY] = lqrb_pkg::GAIN_VELOCITY_RST;
                cfg_image[lqrb_pkg::CFG_GAIN_PITCH]    = lqrb_pkg::GAIN_PITCH_RST;
                cfg_image[lqrb_pkg::CFG_GAIN_RATE]     = lqrb_pkg::GAIN_RATE_RST;
                cfg_image[lqrb_pkg::CFG_PITCH_OFFSET]  = lqrb_pkg::PITCH_OFFSET_RST;
                cfg_image[lqrb_pkg::CFG_DEFAULT_SPEED] = 32'(lqrb_pkg::DEFAULT_SPEED_RST);
                cfg_image[lqrb_pkg::CFG_VOLTAGE_LIMIT] = 32'(lqrb_pkg::VOLTAGE_LIMIT_RST);
            end
            write_config();
            run_profile(60);
        end
    endtask

    task automatic test_profile_tracking();
        for (int p = 0; p < 4; p++) begin
            drain_results();
            if (p > 0) begin
                cfg_image[lqrb_pkg::CFG_GAIN_POSITION] = spread(4000000);
                cfg_image[lqrb_pkg::CFG_GAIN_VELOCITY] = spread(300000);
                cfg_image[lqrb_pkg::CFG_GAIN_PITCH]    = spread(200000);
                cfg_image[lqrb_pkg::CFG_GAIN_RATE]     = spread(50000);
                cfg_image[lqrb_pkg::CFG_PITCH_OFFSET]  = spread(40000);
                cfg_image[lqrb_pkg::CFG_DEFAULT_SPEED] = $urandom_range(0, 40000);
                cfg_image[lqrb_pkg::CFG_VOLTAGE_LIMIT] = $urandom_range(0, 1048576);
                write_config();
            end
            run_profile(400);
        end
    endtask

    // Receiver: random stalls, steady stretches, and a long hold on request.
    initial begin
        forever begin
            if (ready_hold > 0) begin
                out_ready <= 1'b0;
                repeat (ready_hold) @(posedge clk);
                ready_hold = 0;
            end else if (steady || ($urandom_range(0, 3) != 0)) begin
                out_ready <= 1'b1;
                @(posedge clk);
            end else begin
                out_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (out_valid && out_ready) begin
            if (expected_ticks.size() == 0) begin
                errors++;
                $error("result with no item pending: drive_voltage %0d", drive_voltage);
            end else begin
                due = expected_ticks.pop_front();
                if (drive_voltage !== due.drive_voltage)
                    flag_mismatch("drive_voltage", due.drive_voltage, drive_voltage);
                if (ramped_velocity !== due.ramped_velocity)
                    flag_mismatch("ramped_velocity", due.ramped_velocity, ramped_velocity);
                if (position_setpoint !== due.position_setpoint)
                    flag_mismatch("position_setpoint", due.position_setpoint,
                                  position_setpoint);
            end
        end
    end

    initial begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        {measured_position, measured_velocity, measured_pitch, measured_rate,
         target_position, target_velocity, target_pitch, target_rate} <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        reset_predictor();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_register_extremes();
        test_profile_tracking();
        drain_results();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lqrb_pkg.sv
rtl/lqrb_mul.sv
rtl/lqr_balance_with_trapezoid_ramp.sv
rtl/lqrb_checker.sv
sim/testbench.sv
